[src/amm_pkg.sv]
`default_nettype none

package amm_pkg;

   localparam int unsigned REG_COUNT = 6;
   localparam int unsigned SLOT_W = 3;
   localparam int unsigned MASK_W = 6;
   localparam int unsigned HOUR_W = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;
   localparam int unsigned REG_W = 12;
   localparam int unsigned SECS_W = 17;
   localparam int unsigned DIST_W = 19;

   localparam logic [SECS_W-1:0] SECS_PER_DAY = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0] SECS_PER_MIN = 6'd60;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_STOP = 1'b1
   } kind_type;

   typedef logic [SLOT_W-1:0] reg_index_type;

   // Layout of one alarm slot register.
   typedef struct packed {
      logic enable;
      logic [HOUR_W-1:0] hour;
      logic [MINUTE_W-1:0] minute;
   } slot_type;

   typedef slot_type [REG_COUNT-1:0] slot_array_type;

   typedef struct packed {
      kind_type kind;
      logic [HOUR_W-1:0] now_hour;
      logic [MINUTE_W-1:0] now_minute;
      logic [SECOND_W-1:0] now_second;
   } req_item_type;

   typedef struct packed {
      logic [MASK_W-1:0] used;
      logic [MASK_W-1:0] triggered;
      logic ringing;
      logic [SLOT_W-1:0] ring_slot;
   } mark_state_type;

   typedef struct packed {
      logic ring_active;
      logic [SLOT_W-1:0] active_slot;
      logic fired_now;
      logic [MASK_W-1:0] triggered_mask;
      logic next_valid;
      logic [HOUR_W-1:0] next_hour;
      logic [MINUTE_W-1:0] next_minute;
   } rsp_item_type;

endpackage

`default_nettype wire

[src/multi_alarm_matcher.sv]
// Six-slot alarm comparator for a real-time clock.
// Request channel (req_): one transfer per item. tuser carries the kind (tick or
// stop); tdata carries the current hour, minute and second. A tick scans the
// enabled slots and fires the lowest matching slot not yet used this minute; a
// stop silences the ringing alarm.
// Response channel (rsp_): exactly one transfer per request, in order, with the
// ringing state, the triggered marks and the nearest enabled alarm after now.
// Configuration channel (csr_): writes one 12-bit slot register per transfer;
// it is always ready and should only be used while no request is in flight.
// A request transfer is captured in the input register; the slot comparators and
// the minimum search then feed the output register, which drives the response.
// A new request is taken every cycle while responses are taken.
// If the receiver stalls, the output register holds its response and the
// input register fills, after which req_tready drops until rsp_tready returns.
// Synchronous reset clears all marks and the ringing state, empties both
// registers and restores slot k to hour 4k, minute 0, disabled.
`default_nettype none

module multi_alarm_matcher #(
   parameter int unsigned SLOT_COUNT = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,  // [0] kind
   input  logic [23:0] req_tdata,  // [4:0] now_hour, [10:5] now_minute, [16:11] now_second
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] ring_active, [3:1] active_slot, [4] fired_now, [10:5] triggered_mask,
   // [11] next_valid, [16:12] next_hour, [22:17] next_minute
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [amm_pkg::SLOT_W-1:0] csr_index,
   input  logic [amm_pkg::REG_W-1:0]  csr_wdata
);
   import amm_pkg::*;

   slot_array_type slots_ff;
   mark_state_type marks_ff, marks_in;
   logic stage_valid_ff;
   req_item_type stage_ff;
   logic rsp_valid_ff;
   rsp_item_type rsp_ff, rsp_in;
   logic advance, fired;
   logic next_valid;
   logic [HOUR_W-1:0] next_hour;
   logic [MINUTE_W-1:0] next_minute;

   assign csr_ready = 1'b1;
   assign advance = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < REG_COUNT; k++) begin
            slots_ff[k] <= slot_type'({1'b0, HOUR_W'(4 * k), MINUTE_W'(0)});
         end
      end else if (csr_valid && csr_ready && 32'(csr_index) < REG_COUNT) begin
         slots_ff[csr_index] <= slot_type'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_ff <= '{kind: kind_type'(req_tuser[0]),
                       now_hour: req_tdata[4:0],
                       now_minute: req_tdata[10:5],
                       now_second: req_tdata[16:11]};
      end
   end

   amm_scan #(.SLOT_COUNT(SLOT_COUNT)) u_scan (
      .item       (stage_ff),
      .slots      (slots_ff),
      .marks      (marks_ff),
      .marks_next (marks_in),
      .fired      (fired)
   );

   amm_next #(.SLOT_COUNT(SLOT_COUNT)) u_next (
      .item        (stage_ff),
      .slots       (slots_ff),
      .next_valid  (next_valid),
      .next_hour   (next_hour),
      .next_minute (next_minute)
   );

   // Marks are committed at the same edge as the response, so the next item sees them.
   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
      end else if (advance) begin
         marks_ff <= marks_in;
      end
   end

   always_comb begin
      rsp_in.ring_active = marks_in.ringing;
      rsp_in.active_slot = marks_in.ringing ? marks_in.ring_slot : '0;
      rsp_in.fired_now = fired;
      rsp_in.triggered_mask = marks_in.triggered;
      rsp_in.next_valid = next_valid;
      rsp_in.next_hour = next_hour;
      rsp_in.next_minute = next_minute;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0,
                       rsp_ff.next_minute,
                       rsp_ff.next_hour,
                       rsp_ff.next_valid,
                       rsp_ff.triggered_mask,
                       rsp_ff.fired_now,
                       rsp_ff.active_slot,
                       rsp_ff.ring_active};

   a_ring_marked : assert property (@(posedge clock) disable iff (reset)
      marks_ff.ringing |-> marks_ff.triggered[marks_ff.ring_slot])
      else $error("ringing slot has no triggered mark");

   a_silent_slot_zero : assert property (@(posedge clock) disable iff (reset)
      !marks_ff.ringing |-> marks_ff.ring_slot == '0)
      else $error("ring slot not cleared while silent");

   a_fire_rings : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fired_now) |-> rsp_ff.ring_active)
      else $error("fired response without an active alarm");

   a_marks_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(marks_ff))
      else $error("marks changed without an item completing");

endmodule

`default_nettype wire

[src/amm_scan.sv]
`default_nettype none

module amm_scan #(
   parameter int unsigned SLOT_COUNT = 6
) (
   input  amm_pkg::req_item_type   item,
   input  amm_pkg::slot_array_type slots,
   input  amm_pkg::mark_state_type marks,
   output amm_pkg::mark_state_type marks_next,
   output logic                    fired
);
   import amm_pkg::*;

   logic found;
   logic [SLOT_W-1:0] hit_slot;

   // Priority search: the lowest eligible slot that matches wins.
   always_comb begin
      found = 1'b0;
      hit_slot = '0;
      for (int k = 0; k < REG_COUNT; k++) begin
         if (k < SLOT_COUNT && !found && slots[k].enable && !marks.used[k]
             && slots[k].hour == item.now_hour && slots[k].minute == item.now_minute) begin
            found = 1'b1;
            hit_slot = SLOT_W'(k);
         end
      end
   end

   always_comb begin
      marks_next = marks;
      fired = 1'b0;
      if (item.kind == KIND_STOP) begin
         if (marks.ringing) begin
            marks_next.triggered[marks.ring_slot] = 1'b0;
         end
         marks_next.ringing = 1'b0;
         marks_next.ring_slot = '0;
      end else if (found) begin
         if (marks.ringing) begin
            marks_next.triggered[marks.ring_slot] = 1'b0;
         end
         marks_next.triggered[hit_slot] = 1'b1;
         marks_next.used[hit_slot] = 1'b1;
         marks_next.ringing = 1'b1;
         marks_next.ring_slot = hit_slot;
         fired = 1'b1;
      end else begin
         // A used slot becomes eligible again once its minute has passed.
         for (int k = 0; k < REG_COUNT; k++) begin
            if (k < SLOT_COUNT && slots[k].minute != item.now_minute) begin
               marks_next.used[k] = 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

[src/amm_next.sv]
`default_nettype none

module amm_next #(
   parameter int unsigned SLOT_COUNT = 6
) (
   input  amm_pkg::req_item_type        item,
   input  amm_pkg::slot_array_type      slots,
   output logic                         next_valid,
   output logic [amm_pkg::HOUR_W-1:0]   next_hour,
   output logic [amm_pkg::MINUTE_W-1:0] next_minute
);
   import amm_pkg::*;

   logic [SECS_W-1:0] cur_secs;
   logic signed [DIST_W-1:0] ahead [REG_COUNT];
   logic signed [DIST_W-1:0] best;

   assign cur_secs = SECS_W'(item.now_hour * SECS_PER_HOUR)
                   + SECS_W'(item.now_minute * SECS_PER_MIN)
                   + SECS_W'(item.now_second);

   // Distance in seconds from now, folded forward over midnight when not ahead.
   always_comb begin
      logic [SECS_W-1:0] slot_secs;
      logic signed [DIST_W-1:0] diff;
      for (int k = 0; k < REG_COUNT; k++) begin
         slot_secs = SECS_W'(slots[k].hour * SECS_PER_HOUR)
                   + SECS_W'(slots[k].minute * SECS_PER_MIN);
         diff = $signed({2'b00, slot_secs}) - $signed({2'b00, cur_secs});
         if (diff <= 0) begin
            ahead[k] = diff + $signed({2'b00, SECS_PER_DAY});
         end else begin
            ahead[k] = diff;
         end
      end
   end

   // Strict compare keeps the lowest slot on a tie.
   always_comb begin
      next_valid = 1'b0;
      best = '0;
      next_hour = '0;
      next_minute = '0;
      for (int k = 0; k < REG_COUNT; k++) begin
         if (k < SLOT_COUNT && slots[k].enable && (!next_valid || ahead[k] < best)) begin
            next_valid = 1'b1;
            best = ahead[k];
            next_hour = slots[k].hour;
            next_minute = slots[k].minute;
         end
      end
   end

endmodule

`default_nettype wire

[tb/tb_multi_alarm_matcher.sv]
`timescale 1ns / 100ps

module tb_multi_alarm_matcher;
   import amm_pkg::*;

   localparam int unsigned SLOTS = 6;

   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [0:0] req_tuser = 1'b0;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   reg_index_type csr_index = '0;
   logic [REG_W-1:0] csr_wdata = '0;

   // Shadow of the slot registers and of the block's marks.
   slot_type alarm_regs [REG_COUNT];
   logic [MASK_W-1:0] slot_spent;
   logic [MASK_W-1:0] ring_marks;
   logic bell_on;
   logic [SLOT_W-1:0] bell_slot;

   rsp_item_type alarms_expected [$];
   rsp_item_type want_alarm;
   int mismatch_count = 0;
   int response_count = 0;

   // Sender and receiver pacing.
   int burst_left = 0;
   int gap_max = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   int hold_request = 0;
   int hold_left = 0;
   int pattern_count = 0;
   logic [HOUR_W-1:0] last_hour = '0;
   logic [MINUTE_W-1:0] last_minute = '0;

   multi_alarm_matcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),   // [0] kind
      .req_tdata  (req_tdata),   // [4:0] hour, [10:5] minute, [16:11] second, rest zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] active, [3:1] slot, [4] fired, [10:5] marks,
                                 // [11] next valid, [16:12] next hour, [22:17] next minute
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_alarm_shadow();
      for (int k = 0; k < REG_COUNT; k++) begin
         alarm_regs[k] = slot_type'(REG_W'(4 * k) << 6);
      end
      slot_spent = '0;
      ring_marks = '0;
      bell_on = 1'b0;
      bell_slot = '0;
   endfunction

   // Works out the response to one request and advances the shadow marks.
   function automatic rsp_item_type predict_alarm(kind_type kind, logic [HOUR_W-1:0] hour,
                                                  logic [MINUTE_W-1:0] minute,
                                                  logic [SECOND_W-1:0] second);
      rsp_item_type r;
      logic fired;
      logic found;
      int cur_secs;
      int ahead;
      int best;
      r = '0;
      fired = 1'b0;
      found = 1'b0;
      best = 0;
      if (kind == KIND_STOP) begin
         if (bell_on) begin
            ring_marks[bell_slot] = 1'b0;
         end
         bell_on = 1'b0;
         bell_slot = '0;
      end else begin
         for (int k = 0; k < SLOTS; k++) begin
            if (!fired && alarm_regs[k].enable && !slot_spent[k] &&
                alarm_regs[k].hour == hour && alarm_regs[k].minute == minute) begin
               if (bell_on) begin
                  ring_marks[bell_slot] = 1'b0;
               end
               ring_marks[k] = 1'b1;
               slot_spent[k] = 1'b1;
               bell_on = 1'b1;
               bell_slot = SLOT_W'(k);
               fired = 1'b1;
            end
         end
         if (!fired) begin
            for (int k = 0; k < SLOTS; k++) begin
               if (alarm_regs[k].minute != minute) begin
                  slot_spent[k] = 1'b0;
               end
            end
         end
      end
      cur_secs = int'(hour) * 3600 + int'(minute) * 60 + int'(second);
      for (int k = 0; k < SLOTS; k++) begin
         if (alarm_regs[k].enable) begin
            ahead = int'(alarm_regs[k].hour) * 3600 + int'(alarm_regs[k].minute) * 60
                    - cur_secs;
            if (ahead <= 0) begin
               ahead += 86400;
            end
            if (!found || ahead < best) begin
               found = 1'b1;
               best = ahead;
               r.next_hour = alarm_regs[k].hour;
               r.next_minute = alarm_regs[k].minute;
            end
         end
      end
      r.ring_active = bell_on;
      r.active_slot = bell_on ? bell_slot : '0;
      r.fired_now = fired;
      r.triggered_mask = ring_marks;
      r.next_valid = found;
      return r;
   endfunction

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("response %0d: %s expected %0d, got %0d", response_count, field, want, got);
         end
      end
   endfunction

   // Checks every response transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (alarms_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("response %0d: none expected, got %h", response_count, rsp_tdata);
            end
         end else begin
            want_alarm = alarms_expected.pop_front();
            compare_field("ring_active", want_alarm.ring_active, rsp_tdata[0]);
            compare_field("active_slot", want_alarm.active_slot, rsp_tdata[3:1]);
            compare_field("fired_now", want_alarm.fired_now, rsp_tdata[4]);
            compare_field("triggered_mask", want_alarm.triggered_mask, rsp_tdata[10:5]);
            compare_field("next_valid", want_alarm.next_valid, rsp_tdata[11]);
            compare_field("next_hour", want_alarm.next_hour, rsp_tdata[16:12]);
            compare_field("next_minute", want_alarm.next_minute, rsp_tdata[22:17]);
         end
         response_count++;
      end
   end

   // Receiver: a long hold-off when asked for, otherwise the current stall pattern.
   always @(negedge clock) begin
      if (hold_left == 0 && hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         case (rx_mode)
            RX_ALWAYS: begin
               rsp_tready = 1'b1;
            end
            RX_RANDOM: begin
               rsp_tready = ($urandom_range(0, 2) != 0);
            end
            default: begin
               pattern_count = (pattern_count + 1) % 7;
               rsp_tready = (pattern_count >= 2);
            end
         endcase
      end
   end

   task automatic send_request(input kind_type kind, input logic [HOUR_W-1:0] hour,
                               input logic [MINUTE_W-1:0] minute,
                               input logic [SECOND_W-1:0] second);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_tuser = kind;
      req_tdata = {7'b0, second, minute, hour};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      alarms_expected.push_back(predict_alarm(kind, hour, minute, second));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_slot(input reg_index_type index, input logic [REG_W-1:0] word);
      csr_index = index;
      csr_wdata = word;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index < REG_COUNT) begin
         alarm_regs[index] = slot_type'(word);
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_until_idle();
      while (alarms_expected.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   function automatic logic [REG_W-1:0] random_slot_word(int k);
      slot_type w;
      int pick;
      pick = $urandom_range(0, 9);
      w.enable = ($urandom_range(0, 4) != 0);
      w.hour = HOUR_W'($urandom_range(0, 23));
      w.minute = MINUTE_W'($urandom_range(0, 59));
      if (pick == 0) begin
         w = slot_type'(REG_W'($urandom));
      end else if (pick <= 2 && k > 0) begin
         // Same time as an earlier slot, so the lower slot must win.
         w = alarm_regs[$urandom_range(0, k - 1)];
         w.enable = 1'b1;
      end else if (pick == 3 && k > 0) begin
         w.minute = alarm_regs[$urandom_range(0, k - 1)].minute;
      end
      return w;
   endfunction

   task automatic send_random_request();
      slot_type target;
      int pick;
      kind_type kind;
      logic [HOUR_W-1:0] hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      pick = $urandom_range(0, 99);
      kind = KIND_TICK;
      target = alarm_regs[$urandom_range(0, SLOTS - 1)];
      hour = HOUR_W'($urandom_range(0, 23));
      minute = MINUTE_W'($urandom_range(0, 59));
      second = SECOND_W'($urandom_range(0, 59));
      if (pick < 45) begin
         hour = target.hour;
         minute = target.minute;
      end else if (pick < 60) begin
         hour = last_hour;
         minute = last_minute;
      end else if (pick < 72) begin
         kind = KIND_STOP;
      end else if (pick >= 90) begin
         hour = HOUR_W'($urandom);
         minute = MINUTE_W'($urandom);
         second = SECOND_W'($urandom);
      end
      last_hour = hour;
      last_minute = minute;
      send_request(kind, hour, minute, second);
   endtask

   task automatic test_reset_state();
      send_request(KIND_TICK, 5'd4, 6'd0, 6'd0);
      send_request(KIND_STOP, 5'd0, 6'd0, 6'd0);
      send_request(KIND_TICK, 5'd0, 6'd0, 6'd0);
   endtask

   task automatic test_directed_cases();
      wait_until_idle();
      write_slot(3'd0, {1'b1, 5'd7, 6'd30});
      write_slot(3'd1, {1'b1, 5'd7, 6'd30});
      write_slot(3'd2, {1'b1, 5'd23, 6'd59});
      write_slot(3'd3, {1'b1, 5'd0, 6'd0});
      write_slot(3'd4, 12'hFFF);
      write_slot(3'd5, {1'b0, 5'd12, 6'd0});
      // Indexes past the last slot must leave everything alone.
      write_slot(3'd6, 12'h000);
      write_slot(3'd7, 12'h000);
      send_request(KIND_TICK, 5'd7, 6'd29, 6'd59);
      send_request(KIND_TICK, 5'd7, 6'd30, 6'd0);
      // Same minute: slot 0 is spent, so the duplicate in slot 1 takes over.
      send_request(KIND_TICK, 5'd7, 6'd30, 6'd30);
      send_request(KIND_TICK, 5'd7, 6'd30, 6'd59);
      send_request(KIND_STOP, 5'd7, 6'd30, 6'd59);
      send_request(KIND_STOP, 5'd31, 6'd63, 6'd63);
      send_request(KIND_TICK, 5'd7, 6'd31, 6'd0);
      send_request(KIND_TICK, 5'd23, 6'd59, 6'd59);
      send_request(KIND_TICK, 5'd0, 6'd0, 6'd0);
      send_request(KIND_TICK, 5'd31, 6'd63, 6'd63);
      send_request(KIND_TICK, 5'd0, 6'd0, 6'd0);
      send_request(KIND_STOP, 5'd0, 6'd0, 6'd0);
      send_request(KIND_TICK, 5'd12, 6'd0, 6'd0);
      send_request(KIND_TICK, 5'd24, 6'd0, 6'd0);
      send_request(KIND_TICK, 5'd0, 6'd60, 6'd60);
      send_request(KIND_TICK, 5'd7, 6'd30, 6'd1);
      send_request(KIND_TICK, 5'd16, 6'd42, 6'd21);
   endtask

   task automatic test_random_traffic();
      int count;
      for (int phase = 0; phase < 10; phase++) begin
         wait_until_idle();
         for (int k = 0; k < REG_COUNT; k++) begin
            write_slot(reg_index_type'(k), random_slot_word(k));
         end
         if (phase == 0) begin
            // A stretch without any idling on either side.
            rx_mode = RX_ALWAYS;
            gap_max = 0;
         end else begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            gap_max = $urandom_range(0, 12);
         end
         count = $urandom_range(150, 170);
         repeat (count) send_random_request();
      end
      rx_mode = RX_ALWAYS;
      gap_max = 0;
   endtask

   task automatic test_receiver_hold_off();
      gap_max = 0;
      rx_mode = RX_ALWAYS;
      hold_request = 60;
      repeat (50) send_random_request();
      rx_mode = RX_RANDOM;
      gap_max = 3;
      hold_request = 45;
      repeat (50) send_random_request();
      rx_mode = RX_ALWAYS;
   endtask

   initial begin
      clear_alarm_shadow();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_directed_cases();
      test_random_traffic();
      test_receiver_hold_off();
      while (alarms_expected.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(4_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
